@@ rtl/buddy_block_allocator_core_assert.svh @@
// Assertion shorthands shared by the allocator modules.
// Each macro expects clk and arst_n in scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
package bba_pkg;

	localparam int unsigned LEVELS      = 5;
	localparam int unsigned MIN_BLOCK   = 64;
	localparam int unsigned LEAF_BLOCKS = 1 << (LEVELS - 1);
	localparam int unsigned NODES       = 2 * LEAF_BLOCKS - 1;
	localparam int unsigned MIN_SH      = $clog2(MIN_BLOCK);
	localparam int unsigned LOG_REGION  = MIN_SH + LEVELS - 1;
	localparam int unsigned REGION      = MIN_BLOCK << (LEVELS - 1);

	localparam int unsigned LVL_W  = $clog2(LEVELS);
	localparam int unsigned IDX_W  = LEVELS - 1;
	localparam int unsigned NODE_W = $clog2(NODES);
	localparam int unsigned AL_W   = $clog2(LEVELS + 1);

	localparam int unsigned SIZE_W = 16;
	localparam int unsigned OFF_W  = 10;
	localparam int unsigned STAT_W = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
	localparam logic [STAT_W-1:0] ST_ALLOC_FAIL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FREE_IGNORED = 2'd2;

	// Commands from the controller to the datapath.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DESCEND,
		CMD_CLAIM,
		CMD_SPLIT,
		CMD_GRANT,
		CMD_FAIL,
		CMD_RELEASE,
		CMD_MERGE,
		CMD_FINISH,
		CMD_IGNORE
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic tgt_ok;
		logic hit;
		logic lvl_zero;
		logic at_target;
		logic free_ok;
		logic buddy_free;
	} dp_stat_t;

	// Heap position of block idx at level lvl.
	function automatic logic [NODE_W-1:0] node_of(input logic [LVL_W-1:0] lvl,
		input logic [IDX_W-1:0] idx);
		node_of = NODE_W'((32'd1 << lvl) - 32'd1 + 32'(idx));
	endfunction

endpackage

@@ rtl/buddy_block_allocator_core.sv @@
`timescale 1ns / 1ps
// Binary buddy allocator over a 1 KiB region split down to 64-byte leaves in
// five levels. Pulse start with op (0 allocate, 1 free), req_size and
// free_offset while busy is low; the request is taken on that edge. Exactly
// one result beat follows: done is high for a single cycle with block_offset
// and status, and the receiver cannot stall it, so capture it then. An
// allocate loads the request, searches from the target level toward the
// root, claims the lowest free block found and splits it down to the target
// level before the grant, or fails. A free looks up the recorded level,
// releases the block and merges buddy pairs upward while the buddy is free
// and the root is not reached; an ignored free ends after the lookup. The
// controller walks the tree one level per cycle in search, split and merge.
// busy drops in the cycle the result beat is shown, so the next request may
// start in that same cycle. After reset only the whole region is free.
module buddy_block_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [bba_pkg::SIZE_W-1:0]     req_size,
	input  logic [bba_pkg::SIZE_W-1:0]     free_offset,
	output logic                           done,
	output logic [bba_pkg::OFF_W-1:0]      block_offset,
	output logic [bba_pkg::STAT_W-1:0]     status
);
	import bba_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence search, split, lookup and merge steps.
	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold free map, allocation records and the result beat.
	bba_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_size     (req_size),
		.free_offset  (free_offset),
		.stat         (stat),
		.done         (done),
		.block_offset (block_offset),
		.status       (status)
	);

endmodule

@@ rtl/bba_ctrl.sv @@
`timescale 1ns / 1ps
`include "buddy_block_allocator_core_assert.svh"
module bba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t  cmd,
	output logic             busy
);
	import bba_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SPLIT,
		S_LOOKUP,
		S_MERGE
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		cmd     = CMD_NONE;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd     = CMD_LOAD;
					state_d = (op == OP_FREE) ? S_LOOKUP : S_SEARCH;
				end
			end
			S_SEARCH: begin
				priority if (!stat.tgt_ok) begin
					cmd     = CMD_FAIL;
					state_d = S_IDLE;
				end else if (stat.hit) begin
					cmd     = CMD_CLAIM;
					state_d = S_SPLIT;
				end else if (stat.lvl_zero) begin
					cmd     = CMD_FAIL;
					state_d = S_IDLE;
				end else begin
					cmd = CMD_DESCEND;
				end
			end
			S_SPLIT: begin
				if (stat.at_target) begin
					cmd     = CMD_GRANT;
					state_d = S_IDLE;
				end else begin
					cmd = CMD_SPLIT;
				end
			end
			S_LOOKUP: begin
				if (stat.free_ok) begin
					cmd     = CMD_RELEASE;
					state_d = S_MERGE;
				end else begin
					cmd     = CMD_IGNORE;
					state_d = S_IDLE;
				end
			end
			S_MERGE: begin
				if (!stat.lvl_zero && stat.buddy_free) begin
					cmd = CMD_MERGE;
				end else begin
					cmd     = CMD_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

	`BBA_ASSERT_NXT(a_start_sets_busy, state_q == S_IDLE && start, busy, "start not taken")
	`BBA_ASSERT_NXT(a_end_to_idle, cmd == CMD_GRANT || cmd == CMD_FAIL || cmd == CMD_FINISH || cmd == CMD_IGNORE, state_q == S_IDLE && !busy, "no return to idle")

endmodule

@@ rtl/bba_datapath.sv @@
`timescale 1ns / 1ps
`include "buddy_block_allocator_core_assert.svh"
module bba_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bba_pkg::dp_cmd_t               cmd,
	input  logic [bba_pkg::SIZE_W-1:0]     req_size,
	input  logic [bba_pkg::SIZE_W-1:0]     free_offset,
	output bba_pkg::dp_stat_t              stat,
	output logic                           done,
	output logic [bba_pkg::OFF_W-1:0]      block_offset,
	output logic [bba_pkg::STAT_W-1:0]     status
);
	import bba_pkg::*;

	logic [NODES-1:0]    fm_q, fm_d;
	logic [AL_W-1:0]     alloc_level_q [LEAF_BLOCKS];
	logic                done_q;

	logic [LVL_W-1:0]    lvl_q, tgt_q;
	logic [IDX_W-1:0]    idx_q, fin_q;
	logic [SIZE_W-1:0]   off_q;
	logic                tgt_ok_q, range_q;
	logic [OFF_W-1:0]    block_offset_q;
	logic [STAT_W-1:0]   status_q;

	logic [SIZE_W-1:0]   need;
	logic [LVL_W-1:0]    tgt_calc;
	logic                tgt_ok_calc;
	logic                fin_in_range;

	logic [LEVELS-1:0]   hit_lvl;
	logic [IDX_W-1:0]    hit_idx [LEVELS];
	logic                cur_hit;
	logic [IDX_W-1:0]    cur_idx;

	logic [AL_W-1:0]     al_cur;
	logic [LVL_W-1:0]    rel_lvl;
	logic [IDX_W-1:0]    rel_idx;
	logic [31:0]         gnt_off;
	logic [IDX_W-1:0]    gnt_fin;
	logic [IDX_W-1:0]    split_idx;

	// Request decode: round up and pick the finest level that fits.
	always_comb begin
		need        = (32'(req_size) < MIN_BLOCK) ? SIZE_W'(MIN_BLOCK) : req_size;
		tgt_ok_calc = (32'(need) <= REGION);
		tgt_calc    = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if ((REGION >> l) >= 32'(need)) tgt_calc = LVL_W'(l);
		end
		fin_in_range = (32'(free_offset >> MIN_SH) < LEAF_BLOCKS);
	end

	// Lowest free block on every level.
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			hit_lvl[l] = 1'b0;
			hit_idx[l] = '0;
			for (int i = (1 << l) - 1; i >= 0; i--) begin
				if (fm_q[(1 << l) - 1 + i]) begin
					hit_lvl[l] = 1'b1;
					hit_idx[l] = IDX_W'(i);
				end
			end
		end
	end

	assign cur_hit   = hit_lvl[lvl_q];
	assign cur_idx   = hit_idx[lvl_q];
	assign al_cur    = alloc_level_q[fin_q];
	assign rel_lvl   = LVL_W'(al_cur - AL_W'(1));
	assign rel_idx   = IDX_W'(off_q >> (LOG_REGION - 32'(rel_lvl)));
	assign gnt_off   = 32'(idx_q) << (LOG_REGION - 32'(tgt_q));
	assign gnt_fin   = IDX_W'(32'(idx_q) << (LEVELS - 1 - 32'(tgt_q)));
	assign split_idx = IDX_W'((32'(idx_q) << 1) | 32'd1);

	always_comb begin
		fm_d = fm_q;
		unique case (cmd)
			CMD_CLAIM:   fm_d[node_of(lvl_q, cur_idx)] = 1'b0;
			CMD_SPLIT:   fm_d[node_of(LVL_W'(lvl_q + 1'b1), split_idx)] = 1'b1;
			CMD_RELEASE: fm_d[node_of(rel_lvl, rel_idx)] = 1'b1;
			CMD_MERGE: begin
				fm_d[node_of(lvl_q, idx_q)]        = 1'b0;
				fm_d[node_of(lvl_q, idx_q ^ IDX_W'(1))] = 1'b0;
				fm_d[node_of(LVL_W'(lvl_q - 1'b1), idx_q >> 1)] = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.tgt_ok     = tgt_ok_q;
		stat.hit        = cur_hit;
		stat.lvl_zero   = (lvl_q == '0);
		stat.at_target  = (lvl_q == tgt_q);
		stat.free_ok    = range_q && (al_cur != '0) && (32'(al_cur) <= LEVELS);
		stat.buddy_free = fm_q[node_of(lvl_q, idx_q ^ IDX_W'(1))];
	end

	// Allocation state and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_q    <= NODES'(1);
			done_q  <= 1'b0;
			for (int k = 0; k < LEAF_BLOCKS; k++) alloc_level_q[k] <= '0;
		end else begin
			fm_q   <= fm_d;
			done_q <= (cmd == CMD_GRANT) || (cmd == CMD_FAIL) ||
				(cmd == CMD_FINISH) || (cmd == CMD_IGNORE);
			if (cmd == CMD_GRANT) alloc_level_q[gnt_fin] <= AL_W'(tgt_q) + AL_W'(1);
			if (cmd == CMD_RELEASE) alloc_level_q[fin_q] <= '0;
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				lvl_q    <= tgt_calc;
				tgt_q    <= tgt_calc;
				tgt_ok_q <= tgt_ok_calc;
				off_q    <= free_offset;
				fin_q    <= IDX_W'(free_offset >> MIN_SH);
				range_q  <= fin_in_range;
			end
			CMD_DESCEND: lvl_q <= LVL_W'(lvl_q - 1'b1);
			CMD_CLAIM:   idx_q <= cur_idx;
			CMD_SPLIT: begin
				idx_q <= IDX_W'(32'(idx_q) << 1);
				lvl_q <= LVL_W'(lvl_q + 1'b1);
			end
			CMD_GRANT: begin
				block_offset_q <= OFF_W'(gnt_off);
				status_q       <= ST_OK;
			end
			CMD_FAIL: begin
				block_offset_q <= '0;
				status_q       <= ST_ALLOC_FAIL;
			end
			CMD_RELEASE: begin
				lvl_q <= rel_lvl;
				idx_q <= rel_idx;
			end
			CMD_MERGE: begin
				lvl_q <= LVL_W'(lvl_q - 1'b1);
				idx_q <= idx_q >> 1;
			end
			CMD_FINISH: begin
				block_offset_q <= '0;
				status_q       <= ST_OK;
			end
			CMD_IGNORE: begin
				block_offset_q <= '0;
				status_q       <= ST_FREE_IGNORED;
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign block_offset = block_offset_q;
	assign status       = status_q;

	`BBA_ASSERT_IMP(a_claim_needs_hit, cmd == CMD_CLAIM, cur_hit, "claim without free block")
	`BBA_ASSERT_IMP(a_merge_not_root, cmd == CMD_MERGE, lvl_q != '0, "merge above root")
	`BBA_ASSERT_IMP(a_grant_at_target, cmd == CMD_GRANT, lvl_q == tgt_q, "grant off target level")

endmodule

@@ test/buddy_block_allocator_core_checker.sv @@
`timescale 1ns / 1ps
module buddy_block_allocator_core_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          op,
	input  logic [bba_pkg::SIZE_W-1:0]    req_size,
	input  logic [bba_pkg::SIZE_W-1:0]    free_offset,
	input  logic                          done,
	input  logic [bba_pkg::OFF_W-1:0]     block_offset,
	input  logic [bba_pkg::STAT_W-1:0]    status,
	output int                            mismatches,
	output int                            replies_owed
);
	import bba_pkg::*;

	typedef struct {
		logic [OFF_W-1:0]  offset;
		logic [STAT_W-1:0] stat;
	} reply_t;

	bit               free_map [NODES];
	logic [AL_W-1:0]  alloc_level [LEAF_BLOCKS];
	reply_t           replies_due [$];
	reply_t           want;
	int               fail_count = 0;

	function automatic bit block_is_free(int lvl, int idx);
		int n;
		n = (1 << lvl) - 1 + idx;
		return (n < NODES) ? free_map[n] : 1'b0;
	endfunction

	function automatic void mark_block(int lvl, int idx, bit v);
		int n;
		n = (1 << lvl) - 1 + idx;
		if (n < NODES)
			free_map[n] = v;
	endfunction

	// Apply one request to the shadow tree and return the reply it owes.
	function automatic reply_t grant_or_release(logic o, logic [SIZE_W-1:0] sz,
		logic [SIZE_W-1:0] fo);
		reply_t r;
		int need;
		int target;
		int hit_lvl;
		int hit_idx;
		int idx;
		int fin;
		int lvl;
		r.offset = '0;
		r.stat   = ST_OK;
		if (o == OP_ALLOC) begin
			need   = (sz < MIN_BLOCK) ? MIN_BLOCK : int'(sz);
			target = -1;
			for (int l = LEVELS - 1; l >= 0; l--)
				if (target < 0 && (REGION >> l) >= need)
					target = l;
			hit_lvl = -1;
			hit_idx = 0;
			if (target >= 0)
				for (int l = target; l >= 0; l--)
					for (int i = 0; i < (1 << l); i++)
						if (hit_lvl < 0 && block_is_free(l, i)) begin
							hit_lvl = l;
							hit_idx = i;
						end
			if (hit_lvl < 0) begin
				r.stat = ST_ALLOC_FAIL;
			end else begin
				idx = hit_idx;
				mark_block(hit_lvl, idx, 1'b0);
				// split down, handing each right half back to the free map
				for (int l = hit_lvl; l < target; l++) begin
					mark_block(l + 1, 2 * idx + 1, 1'b1);
					idx = 2 * idx;
				end
				r.offset = OFF_W'(idx * (REGION >> target));
				fin = (idx * (REGION >> target)) / MIN_BLOCK;
				if (fin < LEAF_BLOCKS)
					alloc_level[fin] = AL_W'(target + 1);
			end
		end else begin
			fin = fo / MIN_BLOCK;
			if (fin >= LEAF_BLOCKS || alloc_level[fin] == 0 || alloc_level[fin] > LEVELS) begin
				r.stat = ST_FREE_IGNORED;
			end else begin
				lvl = int'(alloc_level[fin]) - 1;
				idx = fo / (REGION >> lvl);
				alloc_level[fin] = '0;
				mark_block(lvl, idx, 1'b1);
				while (lvl > 0 && block_is_free(lvl, idx ^ 1)) begin
					mark_block(lvl, idx, 1'b0);
					mark_block(lvl, idx ^ 1, 1'b0);
					idx = idx >> 1;
					lvl--;
					mark_block(lvl, idx, 1'b1);
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (free_map[n])
				free_map[n] = (n == 0);
			foreach (alloc_level[f])
				alloc_level[f] = '0;
			replies_due.delete();
		end else begin
			// retire the result beat first: a new request may be taken on the same edge
			if (done) begin
				if (replies_due.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with none expected: offset %0d status %0d",
						$time, block_offset, status);
				end else begin
					want = replies_due.pop_front();
					if (block_offset !== want.offset) begin
						fail_count++;
						$display("%0t: block_offset expected %0d actual %0d",
							$time, want.offset, block_offset);
					end
					if (status !== want.stat) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.stat, status);
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(grant_or_release(op, req_size, free_offset));
		end
		mismatches   <= fail_count;
		replies_owed <= replies_due.size();
	end

endmodule

@@ test/buddy_block_allocator_core_test.sv @@
`timescale 1ns / 1ps
module buddy_block_allocator_core_test;
	import bba_pkg::*;

	// Generous ceiling for ~1800 requests, each with its idle gap and busy time.
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 1750;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic               op          = OP_ALLOC;
	logic [SIZE_W-1:0]  req_size    = '0;
	logic [SIZE_W-1:0]  free_offset = '0;
	logic               busy;
	logic               done;
	logic [OFF_W-1:0]   block_offset;
	logic [STAT_W-1:0]  status;
	int                 mismatches;
	int                 replies_owed;
	int                 cycles = 0;

	// Ops of requests in flight, and offsets granted but not yet freed:
	// the latter lets most random frees hit a live allocation.
	logic               ops_in_flight [$];
	logic [SIZE_W-1:0]  live_grants [$];
	bit                 burst = 1'b0;

	buddy_block_allocator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.req_size     (req_size),
		.free_offset  (free_offset),
		.done         (done),
		.block_offset (block_offset),
		.status       (status)
	);

	buddy_block_allocator_core_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.req_size     (req_size),
		.free_offset  (free_offset),
		.done         (done),
		.block_offset (block_offset),
		.status       (status),
		.mismatches   (mismatches),
		.replies_owed (replies_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bail out if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Wait for a clock edge and do the stimulus-side bookkeeping for it, all in this
	// one process so the choice of the next request never races the monitor.
	task automatic tick(output bit taken);
		logic o;
		@(posedge clk);
		if (done && ops_in_flight.size() > 0) begin
			o = ops_in_flight.pop_front();
			if (o == OP_ALLOC && status == ST_OK)
				live_grants.push_back(SIZE_W'(block_offset));
		end
		taken = start && !busy;
		if (taken)
			ops_in_flight.push_back(op);
	endtask

	// Idle for a random gap with junk on the fields, then hold start high with
	// the request until the block takes it. Leave start high so a zero gap on
	// the next request runs back to back.
	task automatic issue(logic o, logic [SIZE_W-1:0] sz, logic [SIZE_W-1:0] fo);
		int gap;
		bit taken;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) begin
				op          <= 1'($urandom_range(0, 1));
				req_size    <= SIZE_W'($urandom);
				free_offset <= SIZE_W'($urandom);
				tick(taken);
			end
		end
		start       <= 1'b1;
		op          <= o;
		req_size    <= sz;
		free_offset <= fo;
		do
			tick(taken);
		while (!taken);
	endtask

	// Sizes spread over every level, with a few zero and oversized requests.
	function automatic logic [SIZE_W-1:0] alloc_size();
		int r;
		int lvl;
		int hi;
		int lo;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return SIZE_W'($urandom_range(REGION + 1, 65535));
		if (r < 13)
			return SIZE_W'($urandom);
		lvl = $urandom_range(0, LEVELS - 1);
		hi  = REGION >> lvl;
		lo  = (lvl == LEVELS - 1) ? 1 : hi / 2 + 1;
		return SIZE_W'($urandom_range(lo, hi));
	endfunction

	// Mostly free live grants (some off by a few bytes inside the first leaf),
	// the rest aligned guesses, unaligned guesses and out-of-range offsets.
	function automatic logic [SIZE_W-1:0] release_offset();
		int r;
		int k;
		logic [SIZE_W-1:0] a;
		r = $urandom_range(0, 99);
		if (r < 65 && live_grants.size() > 0) begin
			k = $urandom_range(0, live_grants.size() - 1);
			a = live_grants[k];
			live_grants.delete(k);
			if ($urandom_range(0, 3) == 0)
				a = a + SIZE_W'($urandom_range(0, MIN_BLOCK - 1));
		end else if (r < 85) begin
			a = SIZE_W'($urandom_range(0, LEAF_BLOCKS - 1) * MIN_BLOCK);
		end else if (r < 93) begin
			a = SIZE_W'($urandom_range(0, REGION - 1));
		end else begin
			a = SIZE_W'($urandom_range(REGION, 65535));
		end
		return a;
	endfunction

	initial begin
		bit taken;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		tick(taken);

		// Whole region, then an unaligned free inside its first leaf.
		issue(OP_ALLOC, 16'd1024, 16'hffff);
		issue(OP_FREE,  16'hffff, 16'd37);
		// Oversized requests fail.
		issue(OP_ALLOC, 16'd1025, 16'd0);
		issue(OP_ALLOC, 16'hffff, 16'd0);
		// Zero size rounds up to one leaf; split all the way down.
		issue(OP_ALLOC, 16'd0,    16'd0);
		issue(OP_ALLOC, 16'd1,    16'd0);
		issue(OP_ALLOC, 16'd64,   16'd0);
		issue(OP_ALLOC, 16'd65,   16'd0);
		issue(OP_ALLOC, 16'd512,  16'd0);
		issue(OP_ALLOC, 16'd256,  16'd0);
		// Nothing large enough is left.
		issue(OP_ALLOC, 16'd1024, 16'd0);
		issue(OP_ALLOC, 16'd512,  16'd0);
		// Out-of-range and unrecorded frees are ignored, as is the double free of 0.
		issue(OP_FREE,  16'd0,    16'd1024);
		issue(OP_FREE,  16'd0,    16'hffff);
		issue(OP_FREE,  16'd0,    16'd960);
		issue(OP_FREE,  16'd0,    16'd0);
		issue(OP_FREE,  16'd0,    16'd0);
		// Unaligned free, then the rest, merging back up to the root (192, 320 ignored).
		issue(OP_FREE,  16'd0,    16'd127);
		issue(OP_FREE,  16'd0,    16'd128);
		issue(OP_FREE,  16'd0,    16'd192);
		issue(OP_FREE,  16'd0,    16'd512);
		issue(OP_FREE,  16'd0,    16'd256);
		issue(OP_FREE,  16'd0,    16'd320);
		issue(OP_ALLOC, 16'd1024, 16'd0);
		issue(OP_FREE,  16'd0,    16'd0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// switch between idling and back-to-back stretches now and then
			if (n % 150 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 0)
				issue(OP_ALLOC, alloc_size(), SIZE_W'($urandom));
			else
				issue(OP_FREE, SIZE_W'($urandom), release_offset());
		end

		// Drop start, drain the owed beats, then let the block settle.
		start <= 1'b0;
		tick(taken);
		while (replies_owed != 0)
			tick(taken);
		repeat (2 * LEVELS + 2)
			tick(taken);

		if (mismatches == 0 && replies_owed == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
